/* design/sha1_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int LEN_OFFSET   = 56;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int SCHED_BITS   = BLOCK_BYTES * 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] ROUND_CONSTS [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    // Working variables of the compression rounds
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_work_t;

endpackage

`default_nettype wire

/* design/sha1_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

`default_nettype wire

/* design/sha1_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

/* design/sha1_round.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha1_round (
    input  logic [6:0]                   round_idx,
    input  sha1_pkg::sha1_work_t         work,
    input  logic [sha1_pkg::SCHED_BITS-1:0] sched,
    output sha1_pkg::sha1_work_t         work_next,
    output logic [31:0]                  sched_word
);
    import sha1_pkg::*;

    logic [31:0] top_word;
    logic [31:0] mix;
    logic [31:0] w;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] rot_a;
    logic [31:0] t;

    // Window words by age: word 0 is the oldest (W[t-16] once expanding)
    assign top_word = sched[SCHED_BITS-1 -: 32];
    assign mix      = sched[SCHED_BITS-1-13*32 -: 32] ^ sched[SCHED_BITS-1-8*32 -: 32]
                    ^ sched[SCHED_BITS-1-2*32 -: 32] ^ top_word;

    // Take the loaded word in the first sixteen rounds, expand after
    assign w          = (round_idx < 7'd16) ? top_word : {mix[30:0], mix[31]};
    assign sched_word = w;

    // Select round function and constant by round group
    always_comb
    begin
        if (round_idx < 7'd20)
        begin
            f = (work.b & work.c) ^ (~work.b & work.d);
            k = ROUND_CONSTS[0];
        end
        else if (round_idx < 7'd40)
        begin
            f = work.b ^ work.c ^ work.d;
            k = ROUND_CONSTS[1];
        end
        else if (round_idx < 7'd60)
        begin
            f = (work.b & work.c) ^ (work.b & work.d) ^ (work.c & work.d);
            k = ROUND_CONSTS[2];
        end
        else
        begin
            f = work.b ^ work.c ^ work.d;
            k = ROUND_CONSTS[3];
        end
    end

    assign rot_a = {work.a[26:0], work.a[31:27]};
    assign t     = rot_a + f + work.e + k + w;

    // Rotate the working variables
    assign work_next.a = t;
    assign work_next.b = work.a;
    assign work_next.c = {work.b[1:0], work.b[31:2]};
    assign work_next.d = work.c;
    assign work_next.e = work.d;

endmodule

`default_nettype wire

/* design/sha1_hash_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// SHA-1 engine taking at most one message byte per transfer on msg_in and
// giving the five digest words, index 0 first, on digest_out after a transfer
// that marks end of message. A byte that does not finish a 64-byte block and
// does not end the message leaves msg_in ready for the next. After a byte that
// finishes a block, msg_in is not ready during the 80 rounds through the single
// round unit and the add into the chaining words. At end of message the padding
// (0x80, zeros, bit length) is shifted in one byte per cycle up to the block
// end and that block is compressed; when the 0x80 lands at offset 56 or later
// the length does not fit, and a second block of padding and a second
// compression follow. The five digest transfers come next, and the engine
// then restarts from the initial hash value.
module sha1_hash_engine (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sha1_in_if.sink     msg_in,
    sha1_out_if.source  digest_out
);
    import sha1_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [5:0] LAST_POS = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_POS  = 6'(LEN_OFFSET);
    localparam logic [6:0] LAST_RND = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

    logic [2:0]            state_reg, state_next;
    logic [2:0]            ret_reg, ret_next;
    logic [6:0]            rnd_reg, rnd_next;
    logic [5:0]            pos_reg, pos_next;
    logic                  pad_first_reg, pad_first_next;
    logic                  len_ok_reg, len_ok_next;
    logic [63:0]           byte_count_reg, byte_count_next;
    logic [31:0]           chain_reg [DIGEST_WORDS];
    logic [31:0]           chain_next [DIGEST_WORDS];
    sha1_work_t            work_reg, work_next;
    logic [SCHED_BITS-1:0] sched_reg, sched_next;
    logic [2:0]            out_idx_reg, out_idx_next;

    sha1_work_t            round_work;
    logic [31:0]           round_word;
    logic                  in_fire;
    logic                  out_fire;
    logic [63:0]           bit_len;
    logic [2:0]            len_lane;
    logic [7:0]            len_byte;
    logic                  len_ok_eff;
    logic [7:0]            pad_byte;
    sha1_work_t            chain_work;

    sha1_round u_round (
        .round_idx  (rnd_reg),
        .work       (work_reg),
        .sched      (sched_reg),
        .work_next  (round_work),
        .sched_word (round_word)
    );

    assign msg_in.ready = (state_reg == ST_IDLE);
    assign in_fire      = msg_in.valid && msg_in.ready;

    assign digest_out.valid       = (state_reg == ST_OUT);
    assign digest_out.digest_word = chain_reg[out_idx_reg];
    assign digest_out.word_index  = out_idx_reg;
    assign digest_out.last_word   = (out_idx_reg == LAST_IDX);
    assign out_fire               = digest_out.valid && digest_out.ready;

    // Length bytes go out most significant first at block offsets 56..63
    assign bit_len  = {byte_count_reg[60:0], 3'b000};
    assign len_lane = ~(pos_reg[2:0] - LEN_POS[2:0]);
    assign len_byte = bit_len[{len_lane, 3'b000} +: 8];

    // Length fits in this block only if the 0x80 landed before offset 56
    assign len_ok_eff = pad_first_reg ? (pos_reg < LEN_POS) : len_ok_reg;

    always_comb
    begin
        if (pad_first_reg)
            pad_byte = PAD_BYTE;
        else if (len_ok_eff && (pos_reg >= LEN_POS))
            pad_byte = len_byte;
        else
            pad_byte = 8'h00;
    end

    assign chain_work = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                          d: chain_reg[3], e: chain_reg[4]};

    // Sequence byte intake, rounds, chaining add, padding and digest output
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        rnd_next        = rnd_reg;
        pos_next        = pos_reg;
        pad_first_next  = pad_first_reg;
        len_ok_next     = len_ok_reg;
        byte_count_next = byte_count_reg;
        chain_next      = chain_reg;
        work_next       = work_reg;
        sched_next      = sched_reg;
        out_idx_next    = out_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pad_first_next = 1'b1;
                    if (msg_in.has_byte)
                    begin
                        sched_next      = {sched_reg[SCHED_BITS-9:0], msg_in.data_byte};
                        byte_count_next = byte_count_reg + 64'd1;
                        pos_next        = pos_reg + 6'd1;
                    end
                    if (msg_in.has_byte && (pos_reg == LAST_POS))
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                        work_next  = chain_work;
                        ret_next   = msg_in.end_of_message ? ST_PAD : ST_IDLE;
                    end
                    else if (msg_in.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                sched_next     = {sched_reg[SCHED_BITS-9:0], pad_byte};
                pos_next       = pos_reg + 6'd1;
                pad_first_next = 1'b0;
                len_ok_next    = len_ok_eff;
                if (pos_reg == LAST_POS)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    work_next  = chain_work;
                    ret_next   = len_ok_eff ? ST_OUT : ST_PAD;
                    // Next block carries the length
                    len_ok_next = 1'b1;
                end
            end

            ST_ROUND:
            begin
                work_next  = round_work;
                sched_next = {sched_reg[SCHED_BITS-33:0], round_word};
                rnd_next   = rnd_reg + 7'd1;
                if (rnd_reg == LAST_RND)
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                state_next    = ret_reg;
            end

            ST_OUT:
            begin
                if (out_fire)
                begin
                    if (out_idx_reg == LAST_IDX)
                    begin
                        // Restart from the initial hash value
                        for (int i = 0; i < DIGEST_WORDS; i++)
                            chain_next[i] = IV_WORDS[i];
                        byte_count_next = '0;
                        pos_next        = '0;
                        out_idx_next    = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            rnd_reg        <= '0;
            pos_reg        <= '0;
            pad_first_reg  <= 1'b0;
            len_ok_reg     <= 1'b0;
            byte_count_reg <= '0;
            out_idx_reg    <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_reg[i] <= IV_WORDS[i];
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            rnd_reg        <= rnd_next;
            pos_reg        <= pos_next;
            pad_first_reg  <= pad_first_next;
            len_ok_reg     <= len_ok_next;
            byte_count_reg <= byte_count_next;
            out_idx_reg    <= out_idx_next;
            chain_reg      <= chain_next;
        end
    end

    // Advance the working variables and message window
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
    end

endmodule

`default_nettype wire
